// File: src/crxf_pkg.sv
// shared types, constants and helpers of the can receive filter and frame ring
`default_nettype none
package crxf_pkg;

   localparam int FIFO_DEPTH     = 16;
   localparam int NUM_ACCEPT_IDS = 6;

   localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int ID_W      = 32;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;
   localparam int MAX_BYTES = 8;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ACCEPT_COUNT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_ACCEPT_ID0   = CSR_IDX_W'(2);

   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_READ
   } crxf_state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } crxf_slot_type;

   typedef struct packed {
      logic enable;
      logic hit;
   } crxf_filt_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] r;
      r = (len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : len;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: src/crxf_if.sv
// channel interfaces: frame/read requests, results and register writes
`default_nettype none
interface crxf_req_if
   import crxf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ID_W-1:0]   frame_id;
   logic [LEN_W-1:0]  frame_len;
   logic [DATA_W-1:0] frame_data;

   modport source (output valid, mode, frame_id, frame_len, frame_data, input ready);
   modport sink   (input valid, mode, frame_id, frame_len, frame_data, output ready);
endinterface

interface crxf_rsp_if
   import crxf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic              read_ok;
   logic [ID_W-1:0]   read_id;
   logic [LEN_W-1:0]  read_len;
   logic [DATA_W-1:0] read_data;
   logic              inbox_nonempty;

   modport source (output valid, accepted, read_ok, read_id, read_len, read_data,
                   inbox_nonempty, input ready);
   modport sink   (input valid, accepted, read_ok, read_id, read_len, read_data,
                   inbox_nonempty, output ready);
endinterface

interface crxf_csr_if
   import crxf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/can_rx_id_filter_fifo.sv
// top level: request control, ring pointers, slot occupancy and result register
//
//   channel  role    handshake     word
//   req_in   sink    valid/ready   mode, frame_id, frame_len, frame_data
//   rsp_out  source  valid/ready   accepted, read_ok, read_id, read_len, read_data,
//                                  inbox_nonempty
//   csr_in   sink    valid/ready   index, data (ready always high)
//
// a frame does the filter compare and slot write at the accept edge, which also
// loads the result into the output register. a read goes through the registered
// read port of the slot memory before its result is loaded. one request is in flight at
// a time; req_in.ready drops while a read is out and while a result is stalled.
// reset clears the pointers and the per-slot occupancy flags, so every slot
// reads as empty at once; the slot memory itself is never cleared.
`default_nettype none
module can_rx_id_filter_fifo
   import crxf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   crxf_req_if.sink   req_in,
   crxf_rsp_if.source rsp_out,
   crxf_csr_if.sink   csr_in
);

   crxf_state_type     state_ff, state_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_DEPTH-1:0] occ_ff, occ_in;
   logic               ok_ff, ok_in;
   logic               nonempty_ff, nonempty_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_ne_ff, rsp_ne_in;

   crxf_filt_type      filt;
   crxf_slot_type      wr_entry, rd_entry;
   logic               out_free;
   logic               take;
   logic               frame_take;
   logic               read_take;
   logic               store;
   logic               read_hit;
   logic [LEN_W-1:0]   len_sat;

   crxf_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .csr_in   (csr_in),
      .frame_id (req_in.frame_id),
      .filt     (filt)
   );

   crxf_slot_ram u_ram (
      .clock    (clock),
      .wr_en    (store),
      .wr_addr  (wr_ptr_ff),
      .wr_entry (wr_entry),
      .rd_en    (read_take),
      .rd_addr  (rd_ptr_ff),
      .rd_entry (rd_entry)
   );

   assign out_free     = !rsp_valid_ff || rsp_out.ready;
   assign req_in.ready = (state_ff == ST_IDLE) && out_free;
   assign take         = req_in.valid && req_in.ready;
   assign frame_take   = take && (req_in.mode == MODE_FRAME);
   assign read_take    = take && (req_in.mode == MODE_READ);
   assign len_sat      = sat_len(req_in.frame_len);
   assign store        = frame_take && (len_sat != '0) && filt.hit;
   assign read_hit     = filt.enable && occ_ff[rd_ptr_ff];

   assign wr_entry.id   = req_in.frame_id;
   assign wr_entry.len  = len_sat;
   assign wr_entry.data = req_in.frame_data & byte_mask(len_sat);

   // pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (store) begin
         occ_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (read_take && read_hit) begin
         occ_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      nonempty_in = filt.enable && occ_in[rd_ptr_in];
      ok_in       = ok_ff;
      if (read_take) begin
         ok_in = read_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ne_ff   <= rsp_ne_in;
      if (read_take) begin
         nonempty_ff <= nonempty_in;
      end
   end

   // next state and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_out.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ne_in    = rsp_ne_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (frame_take) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = store;
               rsp_ok_in    = 1'b0;
               rsp_id_in    = '0;
               rsp_len_in   = '0;
               rsp_data_in  = '0;
               rsp_ne_in    = nonempty_in;
            end else if (read_take) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // slot word is out of the memory now
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b0;
               rsp_ok_in    = ok_ff;
               rsp_id_in    = ok_ff ? rd_entry.id : '0;
               rsp_len_in   = ok_ff ? rd_entry.len : '0;
               rsp_data_in  = ok_ff ? (rd_entry.data & byte_mask(rd_entry.len)) : '0;
               rsp_ne_in    = nonempty_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_out.valid          = rsp_valid_ff;
   assign rsp_out.accepted       = rsp_acc_ff;
   assign rsp_out.read_ok        = rsp_ok_ff;
   assign rsp_out.read_id        = rsp_id_ff;
   assign rsp_out.read_len       = rsp_len_ff;
   assign rsp_out.read_data      = rsp_data_ff;
   assign rsp_out.inbox_nonempty = rsp_ne_ff;

endmodule
`default_nettype wire

// File: src/crxf_slot_ram.sv
// frame slot memory: one write port, one registered read port
`default_nettype none
module crxf_slot_ram
   import crxf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire crxf_slot_type    wr_entry,
   input  wire logic             rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output crxf_slot_type         rd_entry
);

   crxf_slot_type mem_ff [FIFO_DEPTH];
   crxf_slot_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule
`default_nettype wire

// File: src/crxf_filter.sv
// configuration registers and the parallel identifier acceptance compare
`default_nettype none
module crxf_filter
   import crxf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   crxf_csr_if.sink             csr_in,
   input  wire logic [ID_W-1:0] frame_id,
   output crxf_filt_type        filt
);

   logic                 enable_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [ID_W-1:0]      accept_id_ff [NUM_ACCEPT_IDS];
   logic                 csr_take;
   logic [CNT_W-1:0]     count_eff;
   logic                 hit;

   assign csr_in.ready = 1'b1;
   assign csr_take     = csr_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         for (int i = 0; i < NUM_ACCEPT_IDS; i++) begin
            accept_id_ff[i] <= '0;
         end
      end else if (csr_take) begin
         if (csr_in.index == REG_ENABLE) begin
            enable_ff <= csr_in.data[0];
         end
         if (csr_in.index == REG_ACCEPT_COUNT) begin
            count_ff <= csr_in.data[CNT_W-1:0];
         end
         for (int i = 0; i < NUM_ACCEPT_IDS; i++) begin
            if (csr_in.index == REG_ACCEPT_ID0 + CSR_IDX_W'(i)) begin
               accept_id_ff[i] <= csr_in.data[ID_W-1:0];
            end
         end
      end
   end

   // a count beyond the implemented registers uses all of them
   assign count_eff = (count_ff > CNT_W'(NUM_ACCEPT_IDS)) ? CNT_W'(NUM_ACCEPT_IDS) : count_ff;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_ACCEPT_IDS; i++) begin
         if ((CNT_W'(i) < count_eff) && (accept_id_ff[i] == frame_id)) begin
            hit = 1'b1;
         end
      end
   end

   assign filt.enable = enable_ff;
   assign filt.hit    = hit;

endmodule
`default_nettype wire

// File: src/crxf_checker.sv
// port-level checks of the receive filter and frame ring, bound to the top level
`default_nettype none
module crxf_checker
   import crxf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_accepted,
   input wire logic              rsp_read_ok,
   input wire logic [ID_W-1:0]   rsp_read_id,
   input wire logic [LEN_W-1:0]  rsp_read_len,
   input wire logic [DATA_W-1:0] rsp_read_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_read_ok))
      else $error("result flags both a stored frame and a read");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_ok |->
         rsp_read_id == '0 && rsp_read_len == '0 && rsp_read_data == '0)
      else $error("failed or frame result carries read fields");

   a_read_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_ok |->
         rsp_read_len != '0 && rsp_read_len <= LEN_W'(MAX_BYTES))
      else $error("read returned a slot with a bad length");

endmodule

bind can_rx_id_filter_fifo crxf_checker u_crxf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_out.valid),
   .rsp_ready     (rsp_out.ready),
   .rsp_accepted  (rsp_out.accepted),
   .rsp_read_ok   (rsp_out.read_ok),
   .rsp_read_id   (rsp_out.read_id),
   .rsp_read_len  (rsp_out.read_len),
   .rsp_read_data (rsp_out.read_data)
);
`default_nettype wire

// File: verif/tb.sv
// testbench of the can receive filter and frame ring: directed table, then random phases
`default_nettype none
module tb;
   import crxf_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RAND_PHASES  = 11;
   localparam int PHASE_WORDS  = 150;
   localparam int HOLD_AFTER   = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int END_CYCLES   = 20;
   localparam int MAX_PRINTED  = 60;
   localparam int FIRST_UNMAPPED = REG_ACCEPT_ID0 + NUM_ACCEPT_IDS;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = '1;

   typedef struct packed {
      logic              mode;
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } rx_word_type;

   typedef struct packed {
      logic              accepted;
      logic              read_ok;
      logic [ID_W-1:0]   read_id;
      logic [LEN_W-1:0]  read_len;
      logic [DATA_W-1:0] read_data;
      logic              inbox_nonempty;
   } inbox_word_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] val;
      rx_word_type          w;
      bit                   known;
      inbox_word_type       want;
   } stim_row_type;

   typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_style_type;

   logic clock = 1'b0;
   logic reset;

   crxf_req_if req_if ();
   crxf_rsp_if rsp_if ();
   crxf_csr_if csr_if ();

   can_rx_id_filter_fifo dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if),
      .csr_in  (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the registers and the frame ring
   logic                 cfg_enable = 1'b0;
   logic [CNT_W-1:0]     cfg_count  = '0;
   logic [ID_W-1:0]      cfg_ids   [NUM_ACCEPT_IDS] = '{default: '0};
   logic [ID_W-1:0]      ring_id   [FIFO_DEPTH] = '{default: '0};
   logic [LEN_W-1:0]     ring_len  [FIFO_DEPTH] = '{default: '0};
   logic [DATA_W-1:0]    ring_data [FIFO_DEPTH] = '{default: '0};
   logic [PTR_W-1:0]     wr_ptr = '0;
   logic [PTR_W-1:0]     rd_ptr = '0;

   inbox_word_type pending_results[$];

   int mismatches     = 0;
   int results_seen   = 0;
   int words_sent     = 0;
   int frames_stored  = 0;
   int overwrites     = 0;
   int reads_returned = 0;
   int reads_empty    = 0;
   int cycle_count    = 0;

   function automatic inbox_word_type rx_ring_update(input rx_word_type w);
      inbox_word_type   r;
      logic [LEN_W-1:0] n;
      int               in_use;
      int               i;
      bit               hit;
      r = '0;
      if (w.mode == MODE_FRAME) begin
         n = (w.len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : w.len;
         in_use = (cfg_count > NUM_ACCEPT_IDS) ? NUM_ACCEPT_IDS : cfg_count;
         hit = 1'b0;
         for (i = 0; i < in_use; i++) begin
            if (cfg_ids[i] == w.id) hit = 1'b1;
         end
         if (n != '0 && hit) begin
            if (ring_len[wr_ptr] != '0) overwrites++;
            ring_id[wr_ptr]  = w.id;
            ring_len[wr_ptr] = n;
            ring_data[wr_ptr] = (n == LEN_W'(MAX_BYTES)) ? w.data :
                                w.data & ((DATA_W'(1) << (8 * n)) - DATA_W'(1));
            wr_ptr = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
            r.accepted = 1'b1;
            frames_stored++;
         end
      end else begin
         if (cfg_enable && ring_len[rd_ptr] != '0) begin
            r.read_ok   = 1'b1;
            r.read_id   = ring_id[rd_ptr];
            r.read_len  = ring_len[rd_ptr];
            r.read_data = ring_data[rd_ptr];
            ring_id[rd_ptr]   = '0;
            ring_len[rd_ptr]  = '0;
            ring_data[rd_ptr] = '0;
            rd_ptr = (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
            reads_returned++;
         end else begin
            reads_empty++;
         end
      end
      r.inbox_nonempty = cfg_enable && ring_len[rd_ptr] != '0;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DAT_W-1:0] val);
      stim_row_type s;
      s = '{kind: ROW_CSR, idx: idx, val: val, w: '0, known: 1'b0, want: '0};
      return s;
   endfunction

   function automatic stim_row_type word_row(input logic mode, input logic [ID_W-1:0] id,
                                             input logic [LEN_W-1:0] len,
                                             input logic [DATA_W-1:0] data);
      stim_row_type s;
      s = '{kind: ROW_WORD, idx: '0, val: '0, w: '{mode, id, len, data}, known: 1'b0,
            want: '0};
      return s;
   endfunction

   // rows whose result carries no frame: only accepted and inbox_nonempty can be set
   function automatic stim_row_type known_row(input logic mode, input logic [ID_W-1:0] id,
                                              input logic [LEN_W-1:0] len,
                                              input logic [DATA_W-1:0] data,
                                              input logic acc, input logic nonempty);
      stim_row_type s;
      s = word_row(mode, id, len, data);
      s.known = 1'b1;
      s.want.accepted = acc;
      s.want.inbox_nonempty = nonempty;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                  input logic [63:0] got_val);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_val, got_val);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_ENABLE:       cfg_enable = val[0];
         REG_ACCEPT_COUNT: cfg_count  = val[CNT_W-1:0];
         default: begin
            if (idx >= REG_ACCEPT_ID0 && idx < FIRST_UNMAPPED)
               cfg_ids[idx - REG_ACCEPT_ID0] = val;
         end
      endcase
   endtask

   task automatic send_rx_word(input rx_word_type w, input bit known,
                               input inbox_word_type want);
      inbox_word_type guess;
      csr_if.valid      <= 1'b0;
      req_if.valid      <= 1'b1;
      req_if.mode       <= w.mode;
      req_if.frame_id   <= w.id;
      req_if.frame_len  <= w.len;
      req_if.frame_data <= w.data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      guess = rx_ring_update(w);
      pending_results.push_back(known ? want : guess);
      words_sent++;
   endtask

   // registers change only once every result is back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      inbox_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing pending", 64'd0, 64'd1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.accepted !== want.accepted)
               report_mismatch("accepted", want.accepted, rsp_if.accepted);
            if (rsp_if.read_ok !== want.read_ok)
               report_mismatch("read_ok", want.read_ok, rsp_if.read_ok);
            if (rsp_if.read_id !== want.read_id)
               report_mismatch("read_id", want.read_id, rsp_if.read_id);
            if (rsp_if.read_len !== want.read_len)
               report_mismatch("read_len", want.read_len, rsp_if.read_len);
            if (rsp_if.read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_if.read_data);
            if (rsp_if.inbox_nonempty !== want.inbox_nonempty)
               report_mismatch("inbox_nonempty", want.inbox_nonempty, rsp_if.inbox_nonempty);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // result side stalls in stretches of its own, with one long hold-off
   initial begin : result_stalls
      sink_style_type style;
      int             stretch;
      int             k;
      bit             held;
      held = 1'b0;
      k = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         style   = sink_style_type'($urandom_range(0, 3));
         stretch = $urandom_range(20, 200);
         repeat (stretch) begin
            @(posedge clock);
            if (!held && results_seen >= HOLD_AFTER) begin
               rsp_if.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               held = 1'b1;
            end
            case (style)
               SINK_OPEN:   rsp_if.ready <= 1'b1;
               SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
               SINK_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               SINK_SPARSE: rsp_if.ready <= (k % 4 == 0);
            endcase
            k++;
         end
      end
   end

   initial begin : stimulus
      stim_row_type         directed[$];
      rx_word_type          w;
      logic [CSR_DAT_W-1:0] bait;
      logic [CSR_DAT_W-1:0] id_val;
      logic [CNT_W-1:0]     cnt;
      int                   in_use;
      int                   sel;
      int                   ph;
      int                   n;
      int                   burst_left;
      int                   read_pct;
      bit                   gaps_on;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_FRAME;
      req_if.frame_id   <= '0;
      req_if.frame_len  <= '0;
      req_if.frame_data <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= REG_ENABLE;
      csr_if.data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // after reset: disabled, no identifiers in use
      directed.push_back(known_row(MODE_READ, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(known_row(MODE_FRAME, '0, 4'd8, '1, 1'b0, 1'b0));
      directed.push_back(csr_row(REG_ACCEPT_ID0, 32'h0000_0123));
      directed.push_back(csr_row(REG_ACCEPT_ID0 + CSR_IDX_W'(5), 32'hFFFF_FFFF));
      directed.push_back(csr_row(REG_ACCEPT_COUNT, 32'hFFFF_FFFE));
      // frames are stored while disabled but reads fail
      directed.push_back(known_row(MODE_FRAME, 32'h0000_0123, 4'd8, '1, 1'b1, 1'b0));
      directed.push_back(known_row(MODE_READ, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(csr_row(REG_ENABLE, 32'h8000_0001));
      directed.push_back(word_row(MODE_READ, '1, 4'hF, '1));
      directed.push_back(known_row(MODE_READ, '0, '0, '0, 1'b0, 1'b0));
      // length over eight, length zero, one byte, identifier miss
      directed.push_back(word_row(MODE_FRAME, 32'hFFFF_FFFF, 4'hF, 64'h0123_4567_89AB_CDEF));
      directed.push_back(known_row(MODE_FRAME, 32'hFFFF_FFFF, 4'd0, '1, 1'b0, 1'b1));
      directed.push_back(word_row(MODE_FRAME, 32'hFFFF_FFFF, 4'd1, '1));
      directed.push_back(known_row(MODE_FRAME, 32'h0000_0124, 4'd8, '1, 1'b0, 1'b1));
      directed.push_back(word_row(MODE_FRAME, 32'h0000_0123, 4'd4, 64'hDEAD_BEEF_CAFE_F00D));
      directed.push_back(csr_row(REG_ACCEPT_ID0 + CSR_IDX_W'(1), 32'h8000_0000));
      directed.push_back(csr_row(REG_ACCEPT_ID0 + CSR_IDX_W'(2), 32'h7FFF_FFFF));
      directed.push_back(csr_row(REG_ACCEPT_ID0 + CSR_IDX_W'(3), 32'h1FFF_FFFF));
      directed.push_back(csr_row(REG_ACCEPT_ID0 + CSR_IDX_W'(4), 32'h0000_0001));
      // count above the number of identifier registers
      directed.push_back(csr_row(REG_ACCEPT_COUNT, 32'h0000_0007));
      directed.push_back(word_row(MODE_FRAME, 32'h0000_0001, 4'd9, 64'hA5A5_5A5A_0F0F_F0F0));
      directed.push_back(word_row(MODE_FRAME, 32'h8000_0000, 4'd2, 64'hFFFF_0000_FFFF_1234));
      repeat (5) directed.push_back(word_row(MODE_READ, '0, '0, '0));
      directed.push_back(known_row(MODE_READ, '0, '0, '0, 1'b0, 1'b0));
      // a write to an unmapped index must not land in the filter
      directed.push_back(csr_row(REG_UNMAPPED, 32'h0000_00AA));
      directed.push_back(known_row(MODE_FRAME, 32'h0000_00AA, 4'd3, '1, 1'b0, 1'b0));
      directed.push_back(csr_row(REG_ACCEPT_COUNT, 32'h0000_0000));
      directed.push_back(known_row(MODE_FRAME, 32'h0000_0123, 4'd8, '1, 1'b0, 1'b0));

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed[i].idx, directed[i].val);
         end else begin
            send_rx_word(directed[i].w, directed[i].known, directed[i].want);
         end
      end

      bait = '0;
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle();
         if (ph == 3)          cnt = '0;
         else if (ph % 4 == 1) cnt = '1;
         else if (ph % 4 == 0) cnt = CNT_W'(NUM_ACCEPT_IDS);
         else                  cnt = CNT_W'($urandom_range(1, 7));
         write_csr(REG_ACCEPT_COUNT, ($urandom() & ~32'h7) | CSR_DAT_W'(cnt));
         for (n = 0; n < NUM_ACCEPT_IDS; n++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)                id_val = '0;
            else if (sel == 1)           id_val = '1;
            else if (sel == 2 && n != 0) id_val = cfg_ids[n - 1];
            else                         id_val = $urandom();
            write_csr(REG_ACCEPT_ID0 + CSR_IDX_W'(n), id_val);
         end
         if ($urandom_range(0, 1) == 1) begin
            bait = $urandom();
            write_csr(CSR_IDX_W'($urandom_range(FIRST_UNMAPPED, 2**CSR_IDX_W - 1)), bait);
         end
         write_csr(REG_ENABLE, {31'($urandom()), (ph != 2)});

         case (ph % 3)
            0: read_pct = 15;
            1: read_pct = 50;
            default: read_pct = 75;
         endcase
         gaps_on = (ph % 3 != 2);
         in_use = (cfg_count > NUM_ACCEPT_IDS) ? NUM_ACCEPT_IDS : cfg_count;
         burst_left = 0;

         for (n = 0; n < PHASE_WORDS; n++) begin
            w.data = {$urandom(), $urandom()};
            w.id   = $urandom();
            sel    = $urandom_range(0, 9);
            if (sel == 0)      w.len = '0;
            else if (sel == 1) w.len = LEN_W'($urandom_range(MAX_BYTES + 1, 2**LEN_W - 1));
            else               w.len = LEN_W'($urandom_range(1, MAX_BYTES));
            if ($urandom_range(0, 99) < read_pct) begin
               w.mode = MODE_READ;
            end else begin
               w.mode = MODE_FRAME;
               sel = $urandom_range(0, 9);
               if (sel < 6 && in_use > 0)
                  w.id = cfg_ids[$urandom_range(0, in_use - 1)];
               else if (sel == 6)
                  w.id = cfg_ids[$urandom_range(0, NUM_ACCEPT_IDS - 1)] ^
                         (32'h1 << $urandom_range(0, 31));
               else if (sel == 7)
                  w.id = bait;
               else if (sel == 8)
                  w.id = cfg_ids[$urandom_range(0, NUM_ACCEPT_IDS - 1)];
            end
            if (burst_left == 0) begin
               if (gaps_on) begin
                  req_if.valid <= 1'b0;
                  csr_if.valid <= 1'b0;
                  repeat ($urandom_range(1, 12)) @(posedge clock);
               end
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_rx_word(w, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("result words never returned", 64'd0, 64'(pending_results.size()));
      $display("%0d words over the table and %0d random phases: %0d frames stored, %0d over",
               words_sent, RAND_PHASES, frames_stored, overwrites);
      $display("unread slots; %0d reads returned a frame, %0d found none or a disabled block",
               reads_returned, reads_empty);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
